// ----- rtl/core/lsrc_pkg.sv -----
// Shared types and constants for the line segment rectangle clipper.
// Holds coordinate widths, register codes and the structs passed between stages.
// No dependencies.
package lsrc_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * COORD_BITS + 2;
	localparam int NUM_BITS   = 2 * COORD_BITS + 3;
	localparam int DIV_LAT    = COORD_BITS + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [NUM_BITS-1:0]   num_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_RIGHT  = 2'd2,
		REG_TOP    = 2'd3
	} cfg_reg_t;

	localparam coord_t RESET_LOW_EDGE  = coord_t'(40);
	localparam coord_t RESET_HIGH_EDGE = coord_t'(200);

	// Divider slots: x where the line meets the top and bottom edges,
	// y where it meets the right and left edges.
	localparam int DIV_XT = 0;
	localparam int DIV_XB = 1;
	localparam int DIV_YR = 2;
	localparam int DIV_YL = 3;

	typedef struct packed {
		coord_t left;
		coord_t bottom;
		coord_t right;
		coord_t top;
	} rect_t;

	typedef struct packed {
		logic   reject;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} seg_t;

	typedef struct packed {
		num_t  num;
		diff_t den;
	} div_req_t;

	typedef struct packed {
		coord_t quo;
		logic   den_zero;
	} div_res_t;

endpackage

// ----- rtl/core/lsrc_front.sv -----
// Front end of the clipper: trivial reject test, differences, products and numerators.
// Three pipeline stages; depends on lsrc_pkg.
module lsrc_front import lsrc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  coord_t              sx,
	input  coord_t              sy,
	input  coord_t              ex,
	input  coord_t              ey,
	input  rect_t               rect,
	output logic                out_valid,
	output seg_t                out_seg,
	output div_req_t [3:0]      out_req
);

	logic     reject;
	logic     valid_s1, valid_s2, valid_s3;
	seg_t     seg_s1, seg_s2, seg_s3;
	diff_t    dx_s1, dy_s1, dt_s1, db_s1, dr_s1, dl_s1;
	diff_t    dx_s2, dy_s2;
	prod_t    pxd_s2, pyd_s2, pt_s2, pb_s2, pr_s2, pl_s2;
	div_req_t [3:0] req_s3;

	always_comb begin
		reject = (sy > rect.top && ey > rect.top) ||
			(sx > rect.right && ex > rect.right) ||
			(sy < rect.bottom && ey < rect.bottom) ||
			(sx < rect.left && ex < rect.left);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1 <= '{reject: reject, sx: sx, sy: sy, ex: ex, ey: ey};
		dx_s1  <= diff_t'(ex) - diff_t'(sx);
		dy_s1  <= diff_t'(ey) - diff_t'(sy);
		dt_s1  <= diff_t'(rect.top) - diff_t'(sy);
		db_s1  <= diff_t'(rect.bottom) - diff_t'(sy);
		dr_s1  <= diff_t'(rect.right) - diff_t'(sx);
		dl_s1  <= diff_t'(rect.left) - diff_t'(sx);

		seg_s2 <= seg_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		pxd_s2 <= prod_t'(seg_s1.sx) * prod_t'(dy_s1);
		pyd_s2 <= prod_t'(seg_s1.sy) * prod_t'(dx_s1);
		pt_s2  <= prod_t'(dt_s1) * prod_t'(dx_s1);
		pb_s2  <= prod_t'(db_s1) * prod_t'(dx_s1);
		pr_s2  <= prod_t'(dr_s1) * prod_t'(dy_s1);
		pl_s2  <= prod_t'(dl_s1) * prod_t'(dy_s1);

		seg_s3 <= seg_s2;
		req_s3[DIV_XT] <= '{num: num_t'(pxd_s2) + num_t'(pt_s2), den: dy_s2};
		req_s3[DIV_XB] <= '{num: num_t'(pxd_s2) + num_t'(pb_s2), den: dy_s2};
		req_s3[DIV_YR] <= '{num: num_t'(pyd_s2) + num_t'(pr_s2), den: dx_s2};
		req_s3[DIV_YL] <= '{num: num_t'(pyd_s2) + num_t'(pl_s2), den: dx_s2};
	end

	assign out_valid = valid_s3;
	assign out_seg   = seg_s3;
	assign out_req   = req_s3;

endmodule

// ----- rtl/core/lsrc_div.sv -----
// Pipelined signed divider, one quotient bit per stage, truncating toward zero and
// saturating to the coordinate range; depends on lsrc_pkg.
module lsrc_div import lsrc_pkg::*; (
	input  logic     clk,
	input  div_req_t req,
	output div_res_t res
);

	typedef struct packed {
		logic [NUM_BITS-1:0]   rem;
		logic [DIFF_BITS-1:0]  den;
		logic [COORD_BITS-1:0] quo;
		logic                  neg;
		logic                  zero;
		logic                  ovf;
	} dstep_t;

	localparam logic [COORD_BITS-1:0] POS_LIMIT = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] NEG_LIMIT = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [NUM_BITS-1:0]  mag_num_s1;
	logic [DIFF_BITS-1:0] mag_den_s1;
	logic                 neg_s1, zero_s1;
	dstep_t               step_s [COORD_BITS+1];
	dstep_t               step_nxt [COORD_BITS];
	logic [NUM_BITS-1:0]  shifted [COORD_BITS];
	div_res_t             res_s;
	coord_t               quo_fin;

	always_ff @(posedge clk) begin
		mag_num_s1 <= req.num[NUM_BITS-1] ? NUM_BITS'(-req.num) : NUM_BITS'(req.num);
		mag_den_s1 <= req.den[DIFF_BITS-1] ? DIFF_BITS'(-req.den) : DIFF_BITS'(req.den);
		neg_s1     <= req.num[NUM_BITS-1] ^ req.den[DIFF_BITS-1];
		zero_s1    <= (req.den == '0);
	end

	// Each stage tries one quotient bit, from the most significant down.
	always_comb begin
		for (int k = 0; k < COORD_BITS; k++) begin
			shifted[k]  = NUM_BITS'(step_s[k].den) << (COORD_BITS - 1 - k);
			step_nxt[k] = step_s[k];
			if (step_s[k].rem >= shifted[k]) begin
				step_nxt[k].rem                 = step_s[k].rem - shifted[k];
				step_nxt[k].quo[COORD_BITS-1-k] = 1'b1;
			end
		end
	end

	// A quotient of 2^COORD_BITS or more saturates whatever its sign.
	always_ff @(posedge clk) begin
		step_s[0] <= '{rem: mag_num_s1, den: mag_den_s1, quo: '0, neg: neg_s1,
			zero: zero_s1,
			ovf: (mag_num_s1 >= (NUM_BITS'(mag_den_s1) << COORD_BITS))};
		for (int k = 0; k < COORD_BITS; k++) begin
			step_s[k+1] <= step_nxt[k];
		end
	end

	always_comb begin
		priority if (step_s[COORD_BITS].ovf) begin
			quo_fin = step_s[COORD_BITS].neg ? coord_t'(NEG_LIMIT) : coord_t'(POS_LIMIT);
		end else if (!step_s[COORD_BITS].neg) begin
			quo_fin = (step_s[COORD_BITS].quo > POS_LIMIT) ? coord_t'(POS_LIMIT) :
				coord_t'(step_s[COORD_BITS].quo);
		end else begin
			quo_fin = (step_s[COORD_BITS].quo > NEG_LIMIT) ? coord_t'(NEG_LIMIT) :
				coord_t'(-step_s[COORD_BITS].quo);
		end
	end

	always_ff @(posedge clk) begin
		res_s <= '{quo: quo_fin, den_zero: step_s[COORD_BITS].zero};
	end

	assign res = res_s;

endmodule

// ----- rtl/core/lsrc_sel.sv -----
// Output stage: applies the edge moves to each endpoint in order and registers the result.
// Depends on lsrc_pkg.
module lsrc_sel import lsrc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  seg_t           seg,
	input  rect_t          rect,
	input  div_res_t [3:0] quo,
	output logic           done,
	output logic           accepted,
	output coord_t         clipped_start_x,
	output coord_t         clipped_start_y,
	output coord_t         clipped_end_x,
	output coord_t         clipped_end_y
);

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	function automatic point_t clip_point(coord_t px, coord_t py, rect_t r,
		div_res_t [3:0] q);
		point_t p;
		p.x = px;
		p.y = py;
		if (p.y > r.top) begin
			p.y = r.top;
			if (!q[DIV_XT].den_zero) p.x = q[DIV_XT].quo;
		end
		if (p.y < r.bottom) begin
			p.y = r.bottom;
			if (!q[DIV_XB].den_zero) p.x = q[DIV_XB].quo;
		end
		if (p.x > r.right) begin
			p.x = r.right;
			if (!q[DIV_YR].den_zero) p.y = q[DIV_YR].quo;
		end
		if (p.x < r.left) begin
			p.x = r.left;
			if (!q[DIV_YL].den_zero) p.y = q[DIV_YL].quo;
		end
		return p;
	endfunction

	point_t p0, p1;
	logic   done_q, accepted_q;
	point_t p0_q, p1_q;

	always_comb begin
		p0 = clip_point(seg.sx, seg.sy, rect, quo);
		p1 = clip_point(seg.ex, seg.ey, rect, quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	// A rejected segment reports all coordinates as zero.
	always_ff @(posedge clk) begin
		accepted_q <= !seg.reject;
		p0_q       <= seg.reject ? '0 : p0;
		p1_q       <= seg.reject ? '0 : p1;
	end

	assign done            = done_q;
	assign accepted        = accepted_q;
	assign clipped_start_x = p0_q.x;
	assign clipped_start_y = p0_q.y;
	assign clipped_end_x   = p1_q.x;
	assign clipped_end_y   = p1_q.y;

endmodule

// ----- rtl/core/line_segment_rectangle_clipper.sv -----
// Line segment clipper against a configurable axis-aligned rectangle.
// Usage: drive the four endpoint coordinates with start high for one cycle per
// segment; a transaction is taken at each rising edge where start is high and
// busy is low. busy never rises, so a new segment may enter on every cycle.
// Each segment yields exactly one result: done is high for a single cycle with
// accepted and the four clipped coordinates; the receiver cannot hold it off.
// A segment passes from the accepting edge to the edge that takes the result
// through three front stages (reject test and differences, multipliers,
// numerator sums), COORD_BITS + 3 divider stages (magnitude, overflow check,
// one quotient bit per stage, sign and saturation) and one output stage that
// applies the edge moves. Throughput is one segment per cycle, set by the four
// dividers being fully pipelined.
// The rectangle edges are written through the cfg_valid/cfg_ready channel,
// index 0 left, 1 bottom, 2 right, 3 top; cfg_ready is always high. Edges
// should only change while no segment is in flight.
// Reset clears all valid bits and loads edges 40, 40, 200, 200; no result
// appears until a segment has been accepted after reset.
module line_segment_rectangle_clipper import lsrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  coord_t                start_x,
	input  coord_t                start_y,
	input  coord_t                end_x,
	input  coord_t                end_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  coord_t                cfg_data,
	output logic                  done,
	output logic                  accepted,
	output coord_t                clipped_start_x,
	output coord_t                clipped_start_y,
	output coord_t                clipped_end_x,
	output coord_t                clipped_end_y
);

	rect_t          rect_q;
	logic           front_valid;
	seg_t           front_seg;
	div_req_t [3:0] front_req;
	div_res_t [3:0] div_res;
	logic [DIV_LAT-1:0] side_valid_s;
	seg_t           side_seg_s [DIV_LAT];

	// The pipeline never stalls, and configuration writes are always taken.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q <= '{left: RESET_LOW_EDGE, bottom: RESET_LOW_EDGE,
				right: RESET_HIGH_EDGE, top: RESET_HIGH_EDGE};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT:   rect_q.left   <= cfg_data;
				REG_BOTTOM: rect_q.bottom <= cfg_data;
				REG_RIGHT:  rect_q.right  <= cfg_data;
				REG_TOP:    rect_q.top    <= cfg_data;
				default:    rect_q        <= rect_q;
			endcase
		end
	end

	lsrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.sx        (start_x),
		.sy        (start_y),
		.ex        (end_x),
		.ey        (end_y),
		.rect      (rect_q),
		.out_valid (front_valid),
		.out_seg   (front_seg),
		.out_req   (front_req)
	);

	// Four dividers run side by side: top and bottom crossings share the
	// divisor dy, right and left crossings share dx.
	for (genvar d = 0; d < 4; d++) begin : g_div
		lsrc_div u_div (
			.clk (clk),
			.req (front_req[d]),
			.res (div_res[d])
		);
	end

	// The endpoints and reject flag travel alongside the dividers so that
	// they meet the quotients at the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_valid_s <= '0;
		end else begin
			side_valid_s <= {side_valid_s[DIV_LAT-2:0], front_valid};
		end
	end

	always_ff @(posedge clk) begin
		side_seg_s[0] <= front_seg;
		for (int k = 1; k < DIV_LAT; k++) begin
			side_seg_s[k] <= side_seg_s[k-1];
		end
	end

	lsrc_sel u_sel (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (side_valid_s[DIV_LAT-1]),
		.seg             (side_seg_s[DIV_LAT-1]),
		.rect            (rect_q),
		.quo             (div_res),
		.done            (done),
		.accepted        (accepted),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y)
	);

endmodule
